### rtl/s2c_pkg.sv
// Shared constants, tables and types for the spherical to Cartesian converter.
// Used by the channel interfaces, the sine lane and the top level.
package s2c_pkg;

    localparam int RADIUS_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF  = 16;

    // Taylor series depth of the quarter-wave sine
    localparam int SERIES_TERMS = 7;
    // x, x^2, three stages per term, final product
    localparam int LANE_STAGES  = 3 + 3 * SERIES_TERMS;

    localparam int X_W   = 31;   // angle in radians, Q30
    localparam int X2_W  = 32;   // x^2, Q30
    localparam int H_W   = 31;   // Horner accumulator, Q30
    localparam int N_W   = 32;   // dividend of a series term
    localparam int Q_W   = 30;   // quotient estimate / reciprocal
    localparam int D_W   = 8;    // series divisor
    localparam int MAG_W = 31;   // sine magnitude, Q30

    localparam logic [X_W-1:0] Q30_HALF_PI = 31'd1686629713;
    localparam logic [H_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [29:0]    Q30_RND     = 30'h2000_0000;

    // divisor (2k)(2k+1) and floor(2^32 / divisor), indexed by k-1
    localparam logic [D_W-1:0] DIV_TAB [SERIES_TERMS] =
        '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [Q_W-1:0] RECIP_TAB [SERIES_TERMS] =
        '{30'd715827882, 30'd214748364, 30'd102261126, 30'd59652323,
          30'd39045157, 30'd27531841, 30'd20452225};

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sval_t;

endpackage

### rtl/s2c_in_if.sv
// Request channel carrying one spherical point.
// Depends on s2c_pkg for default widths.
interface s2c_in_if
    import s2c_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [RADIUS_BITS-1:0] radius;
    logic signed [ANGLE_BITS-1:0]  polar_angle;
    logic signed [ANGLE_BITS-1:0]  azimuth_angle;

    modport source (output valid, output radius, output polar_angle,
                    output azimuth_angle, input ready);
    modport sink   (input valid, input radius, input polar_angle,
                    input azimuth_angle, output ready);
endinterface

### rtl/s2c_out_if.sv
// Result channel carrying one Cartesian point.
// Depends on s2c_pkg for default widths.
interface s2c_out_if
    import s2c_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [RADIUS_BITS:0] x_coord;
    logic signed [RADIUS_BITS:0] y_coord;
    logic signed [RADIUS_BITS:0] z_coord;

    modport source (output valid, output x_coord, output y_coord,
                    output z_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord,
                    input z_coord, output ready);
endinterface

### rtl/spherical_to_cartesian.sv
// Spherical to Cartesian converter: 27 register stages. Throughput one point
// per cycle while the result side does not stall; a stalled result holds its stage while
// empty stages upstream keep filling. Depth is set by the 7-term sine series
// at three stages per term. Reset clears the valid bits only.
// Depends on s2c_pkg, s2c_in_if, s2c_out_if and s2c_qsine.
module spherical_to_cartesian
    import s2c_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    s2c_in_if.sink   point,
    s2c_out_if.source coord
);

    localparam int OUT_W  = RADIUS_BITS + 1;
    localparam int NS     = LANE_STAGES + 3;
    localparam int PS     = LANE_STAGES + 1;
    localparam int OS     = NS - 1;
    localparam int SCL_W  = RADIUS_BITS + 31;

    logic [NS-1:0]          v_reg;
    logic [NS-1:0]          v_next;
    logic [NS-1:0]          en;

    logic [RADIUS_BITS-1:0] rad_reg [0:NS-2];
    logic [ANGLE_BITS-2:0]  t_reg   [4];
    logic                   tn_reg  [4];
    logic [ANGLE_BITS-2:0]  t_next  [4];
    logic                   tn_next [4];
    sval_t                  lane    [4];

    sval_t                  sv_reg  [3];
    logic [61:0]            pxm;
    logic [61:0]            pym;
    logic [SCL_W-1:0]       scl     [3];
    logic [OUT_W-1:0]       mg      [3];
    logic [OUT_W-1:0]       crd_reg [3];

    // pipeline control: a stage loads when it is empty or its successor moves
    assign en[OS] = !v_reg[OS] || coord.ready;
    for (genvar s = 0; s < OS; s++)
    begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end

    assign v_next      = {v_reg[NS-2:0], point.valid};
    assign point.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_next & en) | (v_reg & ~en);
        end
    end

    // quadrant reduction: lanes are sin phi, cos phi, sin theta, cos theta
    for (genvar i = 0; i < 4; i++)
    begin : g_red
        logic [ANGLE_BITS-1:0] ang;
        logic [1:0]            quad;
        logic [ANGLE_BITS-3:0] frac;

        assign ang  = (i < 2) ? point.polar_angle : point.azimuth_angle;
        assign quad = ang[ANGLE_BITS-1 -: 2] + ((i % 2 == 1) ? 2'd1 : 2'd0);
        assign frac = ang[ANGLE_BITS-3:0];

        assign t_next[i]  = quad[0] ? ({1'b1, {(ANGLE_BITS-2){1'b0}}} -
                                       (ANGLE_BITS-1)'(frac))
                                    : (ANGLE_BITS-1)'(frac);
        assign tn_next[i] = quad[1];

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                t_reg[i]  <= t_next[i];
                tn_reg[i] <= tn_next[i];
            end
        end

        s2c_qsine #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_qsine (
            .clk   (clk),
            .en    (en[LANE_STAGES:1]),
            .t     (t_reg[i]),
            .t_neg (tn_reg[i]),
            .res   (lane[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rad_reg[0] <= point.radius;
        end
    end

    for (genvar s = 1; s < NS - 1; s++)
    begin : g_rad
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rad_reg[s] <= rad_reg[s-1];
            end
        end
    end

    // sin(phi) * cos(theta), sin(phi) * sin(theta)
    assign pxm = 62'(lane[0].mag) * 62'(lane[3].mag) + 62'(Q30_RND);
    assign pym = 62'(lane[0].mag) * 62'(lane[2].mag) + 62'(Q30_RND);

    always_ff @(posedge clk)
    begin
        if (en[PS])
        begin
            sv_reg[0].mag <= pxm[30 +: MAG_W];
            sv_reg[0].neg <= (lane[0].neg != lane[3].neg) && (pxm[30 +: MAG_W] != '0);
            sv_reg[1].mag <= pym[30 +: MAG_W];
            sv_reg[1].neg <= (lane[0].neg != lane[2].neg) && (pym[30 +: MAG_W] != '0);
            sv_reg[2]     <= lane[1];
        end
    end

    // scale by radius, round half up on magnitude, then apply sign
    for (genvar c = 0; c < 3; c++)
    begin : g_scl
        assign scl[c] = SCL_W'(rad_reg[NS-2]) * SCL_W'(sv_reg[c].mag) + SCL_W'(Q30_RND);
        assign mg[c]  = scl[c][30 +: OUT_W];

        always_ff @(posedge clk)
        begin
            if (en[OS])
            begin
                crd_reg[c] <= sv_reg[c].neg ? (OUT_W'(0) - mg[c]) : mg[c];
            end
        end
    end

    assign coord.valid   = v_reg[OS];
    assign coord.x_coord = crd_reg[0];
    assign coord.y_coord = crd_reg[1];
    assign coord.z_coord = crd_reg[2];

endmodule

### rtl/s2c_qsine.sv
// Pipelined quarter-wave sine: binary angle to radians, Horner series, Q30 result.
// Depends on s2c_pkg; stage enables come from the top level.
module s2c_qsine
    import s2c_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  logic [ANGLE_BITS-2:0]  t,
    input  logic                   t_neg,
    output sval_t                  res
);

    localparam int TX_W = ANGLE_BITS + 30;
    localparam int FIN  = LANE_STAGES - 1;
    localparam int X2_LAST = FIN - 4;

    logic [TX_W-1:0]  tx_prod;
    logic [61:0]      sq_prod;
    logic [61:0]      fin_prod;

    logic [X_W-1:0]   x_reg    [0:FIN-1];
    logic             neg_reg  [0:FIN-1];
    logic [X2_W-1:0]  x2_reg   [1:X2_LAST];
    logic [X2_W-1:0]  p_reg    [SERIES_TERMS];
    logic [N_W-1:0]   n_reg    [SERIES_TERMS];
    logic [Q_W-1:0]   q_reg    [SERIES_TERMS];
    logic [H_W-1:0]   h_reg    [SERIES_TERMS];
    logic [MAG_W-1:0] mag_reg;
    logic             mneg_reg;

    assign tx_prod = TX_W'(t) * TX_W'(Q30_HALF_PI) + (TX_W'(1) << (ANGLE_BITS - 3));
    assign sq_prod = 62'(x_reg[0]) * 62'(x_reg[0]) + 62'(Q30_RND);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]   <= tx_prod[ANGLE_BITS-2 +: X_W];
            neg_reg[0] <= t_neg;
        end
        if (en[1])
        begin
            x2_reg[1] <= sq_prod[30 +: X2_W];
        end
    end

    for (genvar s = 1; s < FIN; s++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                x_reg[s]   <= x_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
        if (s >= 2 && s <= X2_LAST)
        begin : g_x2
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    x2_reg[s] <= x2_reg[s-1];
                end
            end
        end
    end

    for (genvar j = 0; j < SERIES_TERMS; j++)
    begin : g_term
        localparam int MS = 2 + 3 * j;
        localparam int DS = MS + 1;
        localparam int CS = MS + 2;
        localparam int KI = SERIES_TERMS - 1 - j;

        logic [H_W-1:0]       h_in;
        logic [62:0]          pm;
        logic [N_W-1:0]       n_sum;
        logic [N_W+Q_W-1:0]   qm;
        logic [Q_W+D_W-1:0]   qd;
        logic [N_W-1:0]       rem;
        logic [Q_W:0]         term;
        logic [H_W-1:0]       h_next;

        if (j == 0)
        begin : g_first
            assign h_in = Q30_ONE;
        end
        else
        begin : g_chain
            assign h_in = h_reg[j-1];
        end

        assign pm    = 63'(x2_reg[MS-1]) * 63'(h_in) + 63'(Q30_RND);
        assign n_sum = p_reg[j] + N_W'(DIV_TAB[KI] >> 1);
        assign qm    = (N_W+Q_W)'(n_sum) * (N_W+Q_W)'(RECIP_TAB[KI]);

        // estimate is low by at most one
        assign qd     = (Q_W+D_W)'(q_reg[j]) * (Q_W+D_W)'(DIV_TAB[KI]);
        assign rem    = n_reg[j] - qd[N_W-1:0];
        assign term   = (rem >= N_W'(DIV_TAB[KI])) ? ((Q_W+1)'(q_reg[j]) + (Q_W+1)'(1))
                                                   : (Q_W+1)'(q_reg[j]);
        assign h_next = (term >= Q30_ONE) ? '0 : Q30_ONE - term;

        always_ff @(posedge clk)
        begin
            if (en[MS])
            begin
                p_reg[j] <= pm[30 +: X2_W];
            end
            if (en[DS])
            begin
                n_reg[j] <= n_sum;
                q_reg[j] <= qm[N_W +: Q_W];
            end
            if (en[CS])
            begin
                h_reg[j] <= h_next;
            end
        end
    end

    assign fin_prod = 62'(x_reg[FIN-1]) * 62'(h_reg[SERIES_TERMS-1]) + 62'(Q30_RND);

    always_ff @(posedge clk)
    begin
        if (en[FIN])
        begin
            mag_reg  <= fin_prod[30 +: MAG_W];
            mneg_reg <= neg_reg[FIN-1] && (fin_prod[30 +: MAG_W] != '0);
        end
    end

    assign res.neg = mneg_reg;
    assign res.mag = mag_reg;

endmodule

### bench/tb_top.sv
// Self-checking bench for spherical_to_cartesian: streams points through the
// request channel and compares each Cartesian result against a fixed-point model.
// Depends on s2c_pkg, s2c_in_if, s2c_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb_top
    import s2c_pkg::*;
();

    localparam int R_W     = 16;
    localparam int A_W     = 16;
    localparam int C_W     = R_W + 1;
    localparam int DRAIN   = 40;

    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic [63:0] QUARTER  = 64'd1 << (A_W - 2);

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } smag_t;

    typedef struct packed {
        logic [C_W-1:0] x;
        logic [C_W-1:0] y;
        logic [C_W-1:0] z;
    } coord_t;

    logic clk;
    logic rst_n;

    s2c_in_if  #(.RADIUS_BITS(R_W), .ANGLE_BITS(A_W)) point_if ();
    s2c_out_if #(.RADIUS_BITS(R_W))                   coord_if ();

    spherical_to_cartesian #(.RADIUS_BITS(R_W), .ANGLE_BITS(A_W)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_if),
        .coord (coord_if)
    );

    coord_t coords_due[$];
    int     errors;
    int     points_sent;
    int     results_checked;
    int     src_idle_pct;
    int     snk_idle_pct;

    // ---------------- fixed-point trig model ----------------
    function automatic logic [63:0] q30_round_mul(logic [63:0] a, logic [63:0] b);
        return (a * b + HALF_Q30) >> 30;
    endfunction

    function automatic logic [63:0] quarter_sine(logic [63:0] t);
        logic [63:0] xr;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] d;
        logic [63:0] term;
        xr = (t * 64'(Q30_HALF_PI) + (64'd1 << (A_W - 3))) >> (A_W - 2);
        x2 = q30_round_mul(xr, xr);
        h  = ONE_Q30;
        for (int k = SERIES_TERMS; k >= 1; k--)
        begin
            d    = 64'(2 * k) * 64'(2 * k + 1);
            term = (q30_round_mul(x2, h) + d / 2) / d;
            h    = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        end
        return q30_round_mul(xr, h);
    endfunction

    function automatic smag_t angle_sine(logic [A_W-1:0] a);
        smag_t       s;
        logic [63:0] f;
        f     = 64'(a[A_W-3:0]);
        s.mag = a[A_W-2] ? quarter_sine(QUARTER - f) : quarter_sine(f);
        s.neg = a[A_W-1] && (s.mag != 0);
        return s;
    endfunction

    function automatic smag_t angle_cosine(logic [A_W-1:0] a);
        return angle_sine(a + A_W'(QUARTER));
    endfunction

    function automatic smag_t smag_mul(smag_t a, smag_t b);
        smag_t p;
        p.mag = q30_round_mul(a.mag, b.mag);
        p.neg = (a.neg != b.neg) && (p.mag != 0);
        return p;
    endfunction

    function automatic logic [C_W-1:0] scale_radius(logic [R_W-1:0] r, smag_t p);
        logic [63:0] m;
        m = (64'(r) * p.mag + HALF_Q30) >> 30;
        if (p.neg)
            m = -m;
        return m[C_W-1:0];
    endfunction

    function automatic coord_t predict_coord(logic [R_W-1:0] r, logic [A_W-1:0] phi,
                                             logic [A_W-1:0] theta);
        coord_t c;
        smag_t  sp;
        sp  = angle_sine(phi);
        c.x = scale_radius(r, smag_mul(sp, angle_cosine(theta)));
        c.y = scale_radius(r, smag_mul(sp, angle_sine(theta)));
        c.z = scale_radius(r, angle_cosine(phi));
        return c;
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------- result side ----------------
    initial
    begin
        coord_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            coord_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [C_W-1:0] want,
                               input logic [C_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        coord_t want;
        if (rst_n)
        begin
            if (point_if.valid && point_if.ready)
                coords_due.push_back(predict_coord(point_if.radius, point_if.polar_angle,
                                                   point_if.azimuth_angle));
            if (coord_if.valid && coord_if.ready)
            begin
                if (coords_due.size() == 0)
                begin
                    $error("unexpected result: x %0d y %0d z %0d", coord_if.x_coord,
                           coord_if.y_coord, coord_if.z_coord);
                    errors++;
                end
                else
                begin
                    want = coords_due.pop_front();
                    check_field("x_coord", want.x, coord_if.x_coord);
                    check_field("y_coord", want.y, coord_if.y_coord);
                    check_field("z_coord", want.z, coord_if.z_coord);
                    results_checked++;
                end
            end
        end
    end

    // ---------------- request side ----------------
    task automatic send_point(input logic [R_W-1:0] r, input logic [A_W-1:0] phi,
                              input logic [A_W-1:0] theta);
        while ($urandom_range(99) < src_idle_pct)
        begin
            point_if.valid <= 1'b0;
            @(posedge clk);
        end
        point_if.valid         <= 1'b1;
        point_if.radius        <= r;
        point_if.polar_angle   <= phi;
        point_if.azimuth_angle <= theta;
        @(posedge clk);
        while (!point_if.ready)
            @(posedge clk);
        points_sent++;
    endtask

    function automatic logic [R_W-1:0] pick_radius();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return R_W'($urandom_range(255));
            default: return R_W'($urandom);
        endcase
    endfunction

    // angles bunched near quadrant boundaries half the time
    function automatic logic [A_W-1:0] pick_angle();
        logic [A_W-3:0] f;
        if ($urandom_range(1))
            return A_W'($urandom);
        f = $urandom_range(1) ? (A_W-2)'($urandom_range(3))
                              : (A_W-2)'(QUARTER - 1 - $urandom_range(3));
        return {2'($urandom_range(3)), f};
    endfunction

    // ---------------- tests ----------------
    task automatic test_axis_points();
        logic [A_W-1:0] angles [8];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                   16'h7FFF, 16'h8001, 16'h2000, 16'hFFFF};
        for (int i = 0; i < 8; i++)
            send_point('1, angles[i], angles[(i * 3) % 8]);
        // half-turn polar angle: sin is zero, x and y must not come out as -0
        send_point('1, 16'h8000, 16'h3039);
        send_point(16'd12345, 16'h8000, 16'hA000);
    endtask

    task automatic test_radius_extremes();
        send_point('0, 16'h0000, 16'h0000);
        send_point('0, 16'hA5A5, 16'h5A5A);
        send_point(16'd1, 16'h2000, 16'h2000);
        send_point(16'd1, 16'hE000, 16'h6000);
        send_point(16'h8000, 16'h7FFF, 16'h7FFF);
        send_point('1, 16'h5555, 16'hAAAA);
        send_point('1, 16'hAAAA, 16'h5555);
        send_point(16'h7FFF, 16'h1234, 16'hEDCB);
    endtask

    task automatic test_random_stream(input int src_pct, input int snk_pct, input int n);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++)
            send_point(pick_radius(), pick_angle(), pick_angle());
    endtask

    initial
    begin
        errors          = 0;
        points_sent     = 0;
        results_checked = 0;
        src_idle_pct    = 15;
        snk_idle_pct    = 61;
        rst_n                  <= 1'b0;
        point_if.valid         <= 1'b0;
        point_if.radius        <= '0;
        point_if.polar_angle   <= '0;
        point_if.azimuth_angle <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_points();
        test_radius_extremes();
        test_random_stream(15, 61, 250);
        test_random_stream(61, 15, 250);
        test_random_stream(0, 0, 250);
        point_if.valid <= 1'b0;

        while (coords_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("tb_top: %0d points sent, %0d results checked", points_sent,
                 results_checked);
        $display("tb_top: axes, half turns, radius extremes, random points under mixed stalls");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
